@@ rtl/nmeax_pkg.sv @@
// Shared types, character codes and constants of the NMEA GGA/RMC field extractor.
package nmeax_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_IDENT,
        PH_GGA,
        PH_RMC
    } phase_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [39:0] ID_GGA = 40'h4750474741;
    localparam logic [39:0] ID_RMC = 40'h4750524D43;

    localparam logic [3:0] IDENT_LEN  = 4'd5;
    localparam logic [3:0] CNT_MAX    = 4'd15;
    localparam logic [3:0] FIELD_TIME = 4'd0;
    localparam logic [3:0] FIELD_LAT  = 4'd1;
    localparam logic [3:0] FIELD_LON  = 4'd3;
    localparam logic [3:0] FIELD_DATE = 4'd8;

    localparam logic KIND_GGA = 1'b0;
    localparam logic KIND_RMC = 1'b1;

    localparam int         WHOLE_W   = 16;
    localparam logic [15:0] WHOLE_MAX = 16'hFFFF;

    // Whole part divided by 100 through a reciprocal, exact for any 16-bit value.
    localparam logic [16:0] DIV100_MULT  = 17'd83887;
    localparam int          DIV100_SHIFT = 23;
    localparam int          DEG_W        = 10;
    localparam int          MIN_PART_W   = 21;
    localparam int          MICRO_SUM_W  = 30;
    localparam logic [29:0] MICRO        = 30'd1000000;

    localparam int LAT_W = 27;
    localparam int LON_W = 28;
    localparam longint unsigned LAT_MAX_MICRO = 64'd90000000;
    localparam longint unsigned LON_MAX_MICRO = 64'd180000000;

    typedef struct packed {
        logic       kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       wrapped;
        logic [6:0] day;
        logic [6:0] month;
        logic [6:0] year;
    } rpt_t;

    function automatic longint unsigned ipow(input longint unsigned base, input int n);
        longint unsigned r;
        r = 1;
        for (int i = 0; i < n; i++) begin
            r = r * base;
        end
        return r;
    endfunction

endpackage

@@ rtl/nmeax_parser.sv @@
// Byte-level sentence parser: identifier match, field counting and report capture.
module nmeax_parser #(
    parameter int FRACTION_DIGITS = 4,
    localparam int FRAC_W = $clog2(nmeax_pkg::ipow(10, FRACTION_DIGITS))
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 byte_valid,
    input  logic [7:0]           rx_byte,
    input  logic [4:0]           utc_offset,
    output logic                 rpt_valid,
    output nmeax_pkg::rpt_t      rpt,
    output logic [15:0]          lat_whole,
    output logic [FRAC_W-1:0]    lat_frac,
    output logic [15:0]          lon_whole,
    output logic [FRAC_W-1:0]    lon_frac
);

    localparam int CNT_W = $clog2(FRACTION_DIGITS + 1);

    nmeax_pkg::phase_t phase_reg, phase_next;
    logic [39:0]       ident_reg, ident_next;
    logic [3:0]        field_reg, field_next;
    logic [3:0]        char_cnt_reg, char_cnt_next;
    logic [23:0]       time_reg, time_next;
    logic [23:0]       date_reg, date_next;
    logic [15:0]       lat_whole_reg, lat_whole_next;
    logic [15:0]       lon_whole_reg, lon_whole_next;
    logic [FRAC_W-1:0] lat_frac_reg, lat_frac_next;
    logic [FRAC_W-1:0] lon_frac_reg, lon_frac_next;
    logic [CNT_W-1:0]  frac_cnt_reg, frac_cnt_next;
    logic              seen_point_reg, seen_point_next;

    logic              rpt_valid_reg;
    nmeax_pkg::rpt_t   rpt_reg, rpt_next;
    logic [15:0]       lat_whole_out_reg, lon_whole_out_reg;
    logic [FRAC_W-1:0] lat_frac_out_reg, lon_frac_out_reg;

    logic              is_dollar, is_comma, is_term, is_digit, is_point;
    logic [3:0]        digit;
    logic              gga_fire, rmc_fire;
    logic [FRAC_W-1:0] place_tab [2**CNT_W];
    logic [15:0]       whole_sel;
    logic [FRAC_W-1:0] frac_sel;
    logic [19:0]       whole_grow;
    logic [15:0]       whole_upd;
    logic [FRAC_W-1:0] frac_upd;
    logic              frac_take;
    logic [6:0]        utc_h, utc_m, utc_s;
    logic [4:0]        h_clamp;
    logic signed [6:0] local_h;

    // Place value of each fraction digit, so the fraction is always held padded.
    for (genvar gi = 0; gi < 2**CNT_W; gi++) begin : g_place
        if (gi < FRACTION_DIGITS) begin : g_used
            assign place_tab[gi] = FRAC_W'(nmeax_pkg::ipow(10, FRACTION_DIGITS - 1 - gi));
        end else begin : g_unused
            assign place_tab[gi] = '0;
        end
    end

    function automatic logic [6:0] bcd_pair(input logic [7:0] p);
        return 7'(p[7:4]) * 7'd10 + 7'(p[3:0]);
    endfunction

    assign is_dollar = (rx_byte == nmeax_pkg::CH_DOLLAR);
    assign is_comma  = (rx_byte == nmeax_pkg::CH_COMMA);
    assign is_point  = (rx_byte == nmeax_pkg::CH_POINT);
    assign is_term   = is_comma || (rx_byte == nmeax_pkg::CH_STAR) ||
                       (rx_byte == nmeax_pkg::CH_CR);
    assign is_digit  = (rx_byte >= nmeax_pkg::CH_ZERO) && (rx_byte <= nmeax_pkg::CH_NINE);
    assign digit     = is_digit ? 4'(rx_byte - nmeax_pkg::CH_ZERO) : 4'd0;

    // Report triggers.
    always_comb begin
        gga_fire = byte_valid && !is_dollar && is_term && (phase_reg == nmeax_pkg::PH_GGA) &&
                   (field_reg == nmeax_pkg::FIELD_LON);
        rmc_fire = byte_valid && !is_dollar && is_term && (phase_reg == nmeax_pkg::PH_RMC) &&
                   (field_reg == nmeax_pkg::FIELD_DATE);
    end

    // Phase transitions.
    always_comb begin
        phase_next = phase_reg;
        if (byte_valid) begin
            if (is_dollar) begin
                phase_next = nmeax_pkg::PH_IDENT;
            end else begin
                case (phase_reg)
                    nmeax_pkg::PH_IDLE: begin
                        phase_next = nmeax_pkg::PH_IDLE;
                    end
                    nmeax_pkg::PH_IDENT: begin
                        if (is_comma) begin
                            if (char_cnt_reg == nmeax_pkg::IDENT_LEN &&
                                ident_reg == nmeax_pkg::ID_GGA) begin
                                phase_next = nmeax_pkg::PH_GGA;
                            end else if (char_cnt_reg == nmeax_pkg::IDENT_LEN &&
                                         ident_reg == nmeax_pkg::ID_RMC) begin
                                phase_next = nmeax_pkg::PH_RMC;
                            end else begin
                                phase_next = nmeax_pkg::PH_IDLE;
                            end
                        end else if (is_term) begin
                            phase_next = nmeax_pkg::PH_IDLE;
                        end
                    end
                    nmeax_pkg::PH_GGA, nmeax_pkg::PH_RMC: begin
                        if (is_term && (gga_fire || rmc_fire || !is_comma)) begin
                            phase_next = nmeax_pkg::PH_IDLE;
                        end
                    end
                    default: begin
                        phase_next = nmeax_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Coordinate accumulation shared by the latitude and longitude fields.
    always_comb begin
        whole_sel  = (field_reg == nmeax_pkg::FIELD_LAT) ? lat_whole_reg : lon_whole_reg;
        frac_sel   = (field_reg == nmeax_pkg::FIELD_LAT) ? lat_frac_reg : lon_frac_reg;
        whole_grow = 20'(whole_sel) * 20'd10 + 20'(digit);
        whole_upd  = (whole_grow > 20'(nmeax_pkg::WHOLE_MAX)) ? nmeax_pkg::WHOLE_MAX :
                     whole_grow[15:0];
        frac_take  = frac_cnt_reg < CNT_W'(FRACTION_DIGITS);
        frac_upd   = frac_sel + FRAC_W'(digit) * place_tab[frac_cnt_reg];
    end

    // Field state.
    always_comb begin
        ident_next      = ident_reg;
        field_next      = field_reg;
        char_cnt_next   = char_cnt_reg;
        time_next       = time_reg;
        date_next       = date_reg;
        lat_whole_next  = lat_whole_reg;
        lon_whole_next  = lon_whole_reg;
        lat_frac_next   = lat_frac_reg;
        lon_frac_next   = lon_frac_reg;
        frac_cnt_next   = frac_cnt_reg;
        seen_point_next = seen_point_reg;
        if (byte_valid) begin
            if (is_dollar) begin
                ident_next      = '0;
                field_next      = '0;
                char_cnt_next   = '0;
                time_next       = '0;
                date_next       = '0;
                lat_whole_next  = '0;
                lon_whole_next  = '0;
                lat_frac_next   = '0;
                lon_frac_next   = '0;
                frac_cnt_next   = '0;
                seen_point_next = 1'b0;
            end else begin
                case (phase_reg)
                    nmeax_pkg::PH_IDENT: begin
                        if (is_comma) begin
                            char_cnt_next = '0;
                        end else if (!is_term) begin
                            ident_next = {ident_reg[31:0], rx_byte};
                            if (char_cnt_reg != nmeax_pkg::CNT_MAX) begin
                                char_cnt_next = char_cnt_reg + 4'd1;
                            end
                        end
                    end
                    nmeax_pkg::PH_GGA, nmeax_pkg::PH_RMC: begin
                        if (is_term) begin
                            if (!gga_fire && !rmc_fire && is_comma) begin
                                if (field_reg != nmeax_pkg::CNT_MAX) begin
                                    field_next = field_reg + 4'd1;
                                end
                                char_cnt_next   = '0;
                                frac_cnt_next   = '0;
                                seen_point_next = 1'b0;
                            end
                        end else begin
                            if (phase_reg == nmeax_pkg::PH_GGA) begin
                                if (field_reg == nmeax_pkg::FIELD_TIME) begin
                                    for (int i = 0; i < 6; i++) begin
                                        if (char_cnt_reg == 4'(i)) begin
                                            time_next[4*(5-i) +: 4] = digit;
                                        end
                                    end
                                end else if (field_reg == nmeax_pkg::FIELD_LAT ||
                                             field_reg == nmeax_pkg::FIELD_LON) begin
                                    if (is_point) begin
                                        seen_point_next = 1'b1;
                                    end else if (is_digit && !seen_point_reg) begin
                                        if (field_reg == nmeax_pkg::FIELD_LAT) begin
                                            lat_whole_next = whole_upd;
                                        end else begin
                                            lon_whole_next = whole_upd;
                                        end
                                    end else if (is_digit && frac_take) begin
                                        if (field_reg == nmeax_pkg::FIELD_LAT) begin
                                            lat_frac_next = frac_upd;
                                        end else begin
                                            lon_frac_next = frac_upd;
                                        end
                                        frac_cnt_next = frac_cnt_reg + CNT_W'(1);
                                    end
                                end
                            end else if (field_reg == nmeax_pkg::FIELD_DATE) begin
                                for (int i = 0; i < 6; i++) begin
                                    if (char_cnt_reg == 4'(i)) begin
                                        date_next[4*(5-i) +: 4] = digit;
                                    end
                                end
                            end
                            if (char_cnt_reg != nmeax_pkg::CNT_MAX) begin
                                char_cnt_next = char_cnt_reg + 4'd1;
                            end
                        end
                    end
                    default: begin
                        ident_next = ident_reg;
                    end
                endcase
            end
        end
    end

    // Time shift to local and report assembly.
    always_comb begin
        utc_h   = bcd_pair(time_reg[23:16]);
        utc_m   = bcd_pair(time_reg[15:8]);
        utc_s   = bcd_pair(time_reg[7:0]);
        h_clamp = (utc_h > 7'd23) ? 5'd23 : utc_h[4:0];
        local_h = $signed({2'b00, h_clamp}) + $signed({{2{utc_offset[4]}}, utc_offset});
        rpt_next = '0;
        if (gga_fire) begin
            rpt_next.kind   = nmeax_pkg::KIND_GGA;
            rpt_next.minute = (utc_m > 7'd59) ? 6'd59 : utc_m[5:0];
            rpt_next.second = (utc_s > 7'd59) ? 6'd59 : utc_s[5:0];
            if (local_h < 7'sd0) begin
                rpt_next.hour    = 5'(local_h + 7'sd24);
                rpt_next.wrapped = 1'b1;
            end else if (local_h >= 7'sd24) begin
                rpt_next.hour    = 5'(local_h - 7'sd24);
                rpt_next.wrapped = 1'b1;
            end else begin
                rpt_next.hour = 5'(local_h);
            end
        end else begin
            rpt_next.kind  = nmeax_pkg::KIND_RMC;
            rpt_next.day   = bcd_pair(date_reg[23:16]);
            rpt_next.month = bcd_pair(date_reg[15:8]);
            rpt_next.year  = bcd_pair(date_reg[7:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= nmeax_pkg::PH_IDLE;
            rpt_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            if (en) begin
                rpt_valid_reg <= gga_fire || rmc_fire;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ident_reg      <= ident_next;
        field_reg      <= field_next;
        char_cnt_reg   <= char_cnt_next;
        time_reg       <= time_next;
        date_reg       <= date_next;
        lat_whole_reg  <= lat_whole_next;
        lon_whole_reg  <= lon_whole_next;
        lat_frac_reg   <= lat_frac_next;
        lon_frac_reg   <= lon_frac_next;
        frac_cnt_reg   <= frac_cnt_next;
        seen_point_reg <= seen_point_next;
        if (gga_fire || rmc_fire) begin
            rpt_reg <= rpt_next;
            // A date report carries no position.
            lat_whole_out_reg <= gga_fire ? lat_whole_reg : '0;
            lat_frac_out_reg  <= gga_fire ? lat_frac_reg : '0;
            lon_whole_out_reg <= gga_fire ? lon_whole_reg : '0;
            lon_frac_out_reg  <= gga_fire ? lon_frac_reg : '0;
        end
    end

    assign rpt_valid = rpt_valid_reg;
    assign rpt       = rpt_reg;
    assign lat_whole = lat_whole_out_reg;
    assign lat_frac  = lat_frac_out_reg;
    assign lon_whole = lon_whole_out_reg;
    assign lon_frac  = lon_frac_out_reg;

endmodule

@@ rtl/nmeax_coord_conv.sv @@
// Four-stage conversion of a ddmm.f coordinate to saturated millionths of a degree.
module nmeax_coord_conv #(
    parameter int FRACTION_DIGITS = 4,
    parameter longint unsigned LIMIT = 90000000,
    parameter int OUT_W = 27,
    localparam int FRAC_W = $clog2(nmeax_pkg::ipow(10, FRACTION_DIGITS))
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [15:0]       whole_in,
    input  logic [FRAC_W-1:0] frac_in,
    output logic [OUT_W-1:0]  micro_out
);

    // Minutes to micro-degrees is x * 50000 / (3 * 10^FD), reduced to lowest terms.
    localparam longint unsigned SCALE  = nmeax_pkg::ipow(10, FRACTION_DIGITS);
    localparam int              P2     = (FRACTION_DIGITS < 4) ? FRACTION_DIGITS : 4;
    localparam int              P5     = (FRACTION_DIGITS < 5) ? FRACTION_DIGITS : 5;
    localparam longint unsigned COMMON = nmeax_pkg::ipow(2, P2) * nmeax_pkg::ipow(5, P5);
    localparam longint unsigned NUM_K  = 50000 / COMMON;
    localparam longint unsigned DEN_K  = (3 * SCALE) / COMMON;
    localparam longint unsigned REM_K  = SCALE * NUM_K;
    localparam int              Y_W    = $clog2(100 * REM_K);
    localparam int              SHIFT  = Y_W + $clog2(DEN_K);
    localparam longint unsigned RECIP  = ((64'd1 << SHIFT) + DEN_K - 1) / DEN_K;
    localparam int              R_W    = $clog2(RECIP + 1);
    localparam int              P_W    = Y_W + R_W;

    logic [32:0]                        q100_prod;
    logic [nmeax_pkg::DEG_W-1:0]        deg1_reg, deg2_reg, deg3_reg;
    logic [15:0]                        whole1_reg;
    logic [FRAC_W-1:0]                  frac1_reg;
    logic [6:0]                         rem100;
    logic [Y_W-1:0]                     y_next, y_reg;
    logic [P_W-1:0]                     recip_prod;
    logic [nmeax_pkg::MIN_PART_W-1:0]   minpart_reg;
    logic [nmeax_pkg::MICRO_SUM_W-1:0]  micro_sum;
    logic [OUT_W-1:0]                   micro_next, micro_reg;

    assign q100_prod  = 33'(whole_in) * 33'(nmeax_pkg::DIV100_MULT);
    assign rem100     = 7'(whole1_reg - 16'(deg1_reg) * 16'd100);
    assign y_next     = Y_W'(rem100) * Y_W'(REM_K) + Y_W'(frac1_reg) * Y_W'(NUM_K);
    assign recip_prod = P_W'(y_reg) * P_W'(RECIP);
    assign micro_sum  = nmeax_pkg::MICRO_SUM_W'(deg3_reg) * nmeax_pkg::MICRO +
                        nmeax_pkg::MICRO_SUM_W'(minpart_reg);
    assign micro_next = (64'(micro_sum) > LIMIT) ? OUT_W'(LIMIT) : OUT_W'(micro_sum);

    always_ff @(posedge aclk) begin
        if (en) begin
            deg1_reg    <= nmeax_pkg::DEG_W'(q100_prod >> nmeax_pkg::DIV100_SHIFT);
            whole1_reg  <= whole_in;
            frac1_reg   <= frac_in;
            deg2_reg    <= deg1_reg;
            y_reg       <= y_next;
            deg3_reg    <= deg2_reg;
            minpart_reg <= nmeax_pkg::MIN_PART_W'(recip_prod >> SHIFT);
            micro_reg   <= micro_next;
        end
    end

    assign micro_out = micro_reg;

endmodule

@@ rtl/nmea_gga_rmc_field_extractor.sv @@
// Top level of the NMEA GGA/RMC field extractor: parser, coordinate pipelines and output.
//
// The block takes GPS receiver bytes on the s_ channel, one byte per transaction,
// and can accept a byte in every cycle. A GPGGA sentence gives one transaction on
// the m_ channel when its longitude field ends (local time and position); a GPRMC
// sentence gives one when its date field ends. All other bytes give nothing.
// m_tuser carries the report kind: 0 for a time and position report, 1 for a date.
// A report reaches m_tvalid through the parser's report register, loaded at the edge
// that accepts the byte ending its field, and then the four-stage coordinate
// pipeline (divide by 100, scale the minutes, reciprocal multiply, add and
// saturate). Throughput is one byte per cycle.
// When the receiver holds m_tready low with a report waiting, the whole pipeline
// and the parser hold and s_tready falls; nothing is lost or repeated.
// cfg_wr_en writes the signed UTC offset in hours from cfg_wr_data, to be done
// while the block is idle. Reset sets the offset to -5, empties the pipeline and
// puts the parser back to waiting for a dollar sign.
module nmea_gga_rmc_field_extractor #(
    parameter int FRACTION_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // rx_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,     // local_hour[4:0], minute[10:5], second[16:11],
                                     // day_wrapped[17], lat_micro_deg[44:18],
                                     // lon_micro_deg[72:45], date_day[79:73],
                                     // date_month[86:80], date_year[93:87], zero pad
    output logic        m_tuser,     // report_kind
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data
);

    localparam int FRAC_W = $clog2(nmeax_pkg::ipow(10, FRACTION_DIGITS));
    localparam int DLY    = 4;

    logic                        en;
    logic                        byte_valid;
    logic [4:0]                  utc_offset_reg;
    logic                        rpt_valid;
    nmeax_pkg::rpt_t             rpt;
    logic [15:0]                 lat_whole, lon_whole;
    logic [FRAC_W-1:0]           lat_frac, lon_frac;
    logic [nmeax_pkg::LAT_W-1:0] lat_micro;
    logic [nmeax_pkg::LON_W-1:0] lon_micro;
    nmeax_pkg::rpt_t             rpt_pipe_reg [DLY];
    logic [DLY-1:0]              valid_pipe_reg;
    nmeax_pkg::rpt_t             rpt_out;

    // Everything moves together unless a finished report is waiting for the receiver.
    assign en         = !valid_pipe_reg[DLY-1] || m_tready;
    assign s_tready   = en;
    assign byte_valid = s_tvalid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            utc_offset_reg <= 5'b11011;
        end else if (cfg_wr_en) begin
            utc_offset_reg <= cfg_wr_data;
        end
    end

    nmeax_parser #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .byte_valid (byte_valid),
        .rx_byte    (s_tdata),
        .utc_offset (utc_offset_reg),
        .rpt_valid  (rpt_valid),
        .rpt        (rpt),
        .lat_whole  (lat_whole),
        .lat_frac   (lat_frac),
        .lon_whole  (lon_whole),
        .lon_frac   (lon_frac)
    );

    nmeax_coord_conv #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .LIMIT           (nmeax_pkg::LAT_MAX_MICRO),
        .OUT_W           (nmeax_pkg::LAT_W)
    ) u_lat_conv (
        .aclk      (aclk),
        .en        (en),
        .whole_in  (lat_whole),
        .frac_in   (lat_frac),
        .micro_out (lat_micro)
    );

    nmeax_coord_conv #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .LIMIT           (nmeax_pkg::LON_MAX_MICRO),
        .OUT_W           (nmeax_pkg::LON_W)
    ) u_lon_conv (
        .aclk      (aclk),
        .en        (en),
        .whole_in  (lon_whole),
        .frac_in   (lon_frac),
        .micro_out (lon_micro)
    );

    // Time and date fields ride alongside the coordinate pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_pipe_reg <= '0;
        end else if (en) begin
            valid_pipe_reg <= {valid_pipe_reg[DLY-2:0], rpt_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rpt_pipe_reg[0] <= rpt;
            for (int i = 1; i < DLY; i++) begin
                rpt_pipe_reg[i] <= rpt_pipe_reg[i-1];
            end
        end
    end

    assign rpt_out  = rpt_pipe_reg[DLY-1];
    assign m_tvalid = valid_pipe_reg[DLY-1];
    assign m_tuser  = rpt_out.kind;
    assign m_tdata  = {2'b00, rpt_out.year, rpt_out.month, rpt_out.day, lon_micro, lat_micro,
                       rpt_out.wrapped, rpt_out.second, rpt_out.minute, rpt_out.hour};

endmodule
